@@ hw/rtl/wsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wsp_pkg;

    localparam int COEF_COUNT = 16;
    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    // clip value: three floored products plus translation
    localparam int CLIP_W     = 66 - FRAC_BITS;
    localparam int SIZE_W     = 15;
    localparam int HALF_W     = SIZE_W - 1;
    localparam int PROD_W     = CLIP_W + HALF_W;
    // quotient bits kept; anything at or above 2^QUO_W is flagged as overflow
    localparam int QUO_W      = 42;
    localparam int CAP_EXP    = 40;
    localparam int REM_W      = CLIP_W + 1;
    localparam int SUM_W      = 43;
    localparam int THR        = ((1 << FRAC_BITS) + 5) / 10;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PROJ  = 1'b1;

    localparam logic [QUO_W-1:0] QUO_CAP =
        {{(QUO_W-1-CAP_EXP){1'b0}}, 1'b1, {CAP_EXP{1'b0}}};

    typedef logic [COEF_COUNT-1:0][WORD_W-1:0] t_coef_arr;

    typedef struct packed {
        logic vld;
        logic on;
        logic negx;
        logic negy;
        logic ovx;
        logic ovy;
    } t_flags;

endpackage
`default_nettype wire

@@ hw/rtl/wsp_clip.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Clip x, y, w: products in stage 1, floored sums in stage 2.
module wsp_clip (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_vld,
    input  wire wsp_pkg::t_coef_arr                i_coef,
    input  wire logic signed [wsp_pkg::WORD_W-1:0] i_pos_x,
    input  wire logic signed [wsp_pkg::WORD_W-1:0] i_pos_y,
    input  wire logic signed [wsp_pkg::WORD_W-1:0] i_pos_z,
    output logic                                   o_vld,
    output logic signed [wsp_pkg::CLIP_W-1:0]      o_cx,
    output logic signed [wsp_pkg::CLIP_W-1:0]      o_cy,
    output logic signed [wsp_pkg::CLIP_W-1:0]      o_cw
);

    logic signed [2*wsp_pkg::WORD_W-1:0] r_mx [0:2];
    logic signed [2*wsp_pkg::WORD_W-1:0] r_my [0:2];
    logic signed [2*wsp_pkg::WORD_W-1:0] r_mz [0:2];
    logic signed [wsp_pkg::WORD_W-1:0]   r_mt [0:2];
    logic signed [wsp_pkg::CLIP_W-1:0]   r_c  [0:2];
    logic                                r_vld1;
    logic                                r_vld2;

    genvar k;
    for (k = 0; k < 3; k++) begin : g_row
        // rows 0, 1 and 3 (x, y, w); column-major slot c*4+r
        localparam int ROW = (k == 2) ? 3 : k;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mx[k] <= $signed(i_coef[ROW])      * i_pos_x;
                r_my[k] <= $signed(i_coef[4 + ROW])  * i_pos_y;
                r_mz[k] <= $signed(i_coef[8 + ROW])  * i_pos_z;
                r_mt[k] <= $signed(i_coef[12 + ROW]);
                // arithmetic shift floors toward minus infinity
                r_c[k]  <= wsp_pkg::CLIP_W'(r_mx[k] >>> wsp_pkg::FRAC_BITS)
                         + wsp_pkg::CLIP_W'(r_my[k] >>> wsp_pkg::FRAC_BITS)
                         + wsp_pkg::CLIP_W'(r_mz[k] >>> wsp_pkg::FRAC_BITS)
                         + wsp_pkg::CLIP_W'(r_mt[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    assign o_vld = r_vld2;
    assign o_cx  = r_c[0];
    assign o_cy  = r_c[1];
    assign o_cw  = r_c[2];

endmodule
`default_nettype wire

@@ hw/rtl/wsp_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage.
module wsp_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [wsp_pkg::REM_W-1:0]     i_rem,
    input  wire logic [wsp_pkg::QUO_W-1:0]     i_low,
    input  wire logic [wsp_pkg::CLIP_W-1:0]    i_den,
    output logic [wsp_pkg::QUO_W-1:0]          o_quo
);

    logic [wsp_pkg::REM_W-1:0]  r_rem [0:wsp_pkg::QUO_W-1];
    logic [wsp_pkg::QUO_W-1:0]  r_low [0:wsp_pkg::QUO_W-1];
    logic [wsp_pkg::CLIP_W-1:0] r_den [0:wsp_pkg::QUO_W-1];
    logic [wsp_pkg::QUO_W-1:0]  r_quo [0:wsp_pkg::QUO_W-1];

    genvar j;
    for (j = 0; j < wsp_pkg::QUO_W; j++) begin : g_stage
        logic [wsp_pkg::REM_W-1:0]  rem_in;
        logic [wsp_pkg::QUO_W-1:0]  low_in;
        logic [wsp_pkg::CLIP_W-1:0] den_in;
        logic [wsp_pkg::QUO_W-1:0]  quo_in;
        logic [wsp_pkg::REM_W-1:0]  trial;
        logic                       ge;

        if (j == 0) begin : g_first
            assign rem_in = i_rem;
            assign low_in = i_low;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign low_in = r_low[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
        end

        assign trial = {rem_in[wsp_pkg::REM_W-2:0], low_in[wsp_pkg::QUO_W-1]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? (trial - {1'b0, den_in}) : trial;
                r_low[j] <= {low_in[wsp_pkg::QUO_W-2:0], 1'b0};
                r_den[j] <= den_in;
                r_quo[j] <= {quo_in[wsp_pkg::QUO_W-2:0], ge};
            end
        end
    end

    assign o_quo = r_quo[wsp_pkg::QUO_W-1];

endmodule
`default_nettype wire

@@ hw/rtl/world_to_screen_projection.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipeline from an accepted projection beat to its result beat
// (2 clip stages, scale multiply, divider setup, 42 divider stages, output).
// Throughput: one beat per cycle; the whole pipe advances together and holds on
// output backpressure. Coefficient writes give no result.
// Reset (synchronous, active low): coefficients to zero, width 1920, height
// 1080, all valid bits cleared; no beat is taken while reset is held.
module world_to_screen_projection (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config write port
    input  wire logic                            i_cfg_we,
    input  wire logic [wsp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [wsp_pkg::SIZE_W-1:0]      i_cfg_wdata,
    // input stream
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: coef_index[3:0], coef_value[35:4], pos_x[67:36], pos_y[99:68],
    //        pos_z[131:100], zero pad[135:132]
    input  wire logic [135:0]                    i_s_axis_tdata,
    // tuser: req_type
    input  wire logic                            i_s_axis_tuser,
    // output stream
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // tdata: screen_x[31:0], screen_y[63:32]
    output logic [63:0]                          o_m_axis_tdata,
    // tuser: on_screen
    output logic                                 o_m_axis_tuser
);

    localparam int SH = wsp_pkg::QUO_W - wsp_pkg::FRAC_BITS;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] INT_MIN = 32'sh80000000;

    logic                             w_en;
    logic                             w_acc;
    wsp_pkg::t_coef_arr               r_coef;
    logic [wsp_pkg::SIZE_W-1:0]       r_width;
    logic [wsp_pkg::SIZE_W-1:0]       r_height;
    logic [wsp_pkg::HALF_W-1:0]       w_hw;
    logic [wsp_pkg::HALF_W-1:0]       w_hh;

    logic                             w_c_vld;
    logic signed [wsp_pkg::CLIP_W-1:0] w_cx, w_cy, w_cw;

    // stage 3
    logic                             r3_vld, r3_on, r3_negx, r3_negy;
    logic [wsp_pkg::PROD_W-1:0]       r3_px, r3_py;
    logic [wsp_pkg::CLIP_W-1:0]       r3_w;
    logic [wsp_pkg::CLIP_W-1:0]       w_magx, w_magy;

    // stage 4
    wsp_pkg::t_flags                  r4_fl;
    logic [wsp_pkg::REM_W-1:0]        r4_remx, r4_remy;
    logic [wsp_pkg::QUO_W-1:0]        r4_lowx, r4_lowy;
    logic [wsp_pkg::CLIP_W-1:0]       r4_w;

    wsp_pkg::t_flags                  r_fl [0:wsp_pkg::QUO_W-1];
    logic [wsp_pkg::QUO_W-1:0]        w_qx, w_qy;

    // final map
    wsp_pkg::t_flags                  w_lf;
    logic [wsp_pkg::QUO_W-1:0]        w_capx, w_capy;
    logic signed [wsp_pkg::SUM_W-1:0] w_tx, w_ty, w_sx, w_sy;
    logic [31:0]                      n_ox, n_oy;

    logic                             r_out_vld;
    logic                             r_out_on;
    logic [31:0]                      r_out_x, r_out_y;

    // one enable for every stage: move unless the output beat is stuck
    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en && i_rst_n;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // ---- configuration and coefficient store ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= wsp_pkg::SIZE_W'(1920);
            r_height <= wsp_pkg::SIZE_W'(1080);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wsp_pkg::CFG_WIDTH:  r_width  <= i_cfg_wdata;
                wsp_pkg::CFG_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // half sizes, truncated
    assign w_hw = r_width[wsp_pkg::SIZE_W-1:1];
    assign w_hh = r_height[wsp_pkg::SIZE_W-1:1];

    // a write lands at its own beat, so later projections see it and
    // earlier ones have already taken their products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (w_acc && i_s_axis_tuser == wsp_pkg::REQ_WRITE) begin
            r_coef[i_s_axis_tdata[3:0]] <= i_s_axis_tdata[35:4];
        end
    end

    // ---- stages 1-2: clip coordinates ----
    wsp_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_s_axis_tvalid && i_s_axis_tuser == wsp_pkg::REQ_PROJ),
        .i_coef  (r_coef),
        .i_pos_x ($signed(i_s_axis_tdata[67:36])),
        .i_pos_y ($signed(i_s_axis_tdata[99:68])),
        .i_pos_z ($signed(i_s_axis_tdata[131:100])),
        .o_vld   (w_c_vld),
        .o_cx    (w_cx),
        .o_cy    (w_cy),
        .o_cw    (w_cw)
    );

    // ---- stage 3: on-screen test and |clip| * half ----
    assign w_magx = w_cx[wsp_pkg::CLIP_W-1] ? wsp_pkg::CLIP_W'(-w_cx) : w_cx;
    assign w_magy = w_cy[wsp_pkg::CLIP_W-1] ? wsp_pkg::CLIP_W'(-w_cy) : w_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= w_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_on   <= w_cw >= $signed(wsp_pkg::CLIP_W'(wsp_pkg::THR));
            r3_negx <= w_cx[wsp_pkg::CLIP_W-1];
            r3_negy <= w_cy[wsp_pkg::CLIP_W-1];
            r3_px   <= w_magx * w_hw;
            r3_py   <= w_magy * w_hh;
            r3_w    <= w_cw;
        end
    end

    // ---- stage 4: divider setup ----
    // numerator is prod << FRAC_BITS; its bits above QUO_W form the first
    // partial remainder, and if that is already >= w the quotient overflows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_fl <= '0;
        end else if (w_en) begin
            r4_fl.vld  <= r3_vld;
            r4_fl.on   <= r3_on;
            r4_fl.negx <= r3_negx;
            r4_fl.negy <= r3_negy;
            r4_fl.ovx  <= (r3_px >> SH) >= wsp_pkg::PROD_W'(r3_w);
            r4_fl.ovy  <= (r3_py >> SH) >= wsp_pkg::PROD_W'(r3_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_remx <= wsp_pkg::REM_W'(r3_px >> SH);
            r4_remy <= wsp_pkg::REM_W'(r3_py >> SH);
            r4_lowx <= {r3_px[SH-1:0], {wsp_pkg::FRAC_BITS{1'b0}}};
            r4_lowy <= {r3_py[SH-1:0], {wsp_pkg::FRAC_BITS{1'b0}}};
            r4_w    <= r3_w;
        end
    end

    // ---- divider stages, flags ride alongside ----
    wsp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (r4_remx),
        .i_low (r4_lowx),
        .i_den (r4_w),
        .o_quo (w_qx)
    );

    wsp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (r4_remy),
        .i_low (r4_lowy),
        .i_den (r4_w),
        .o_quo (w_qy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < wsp_pkg::QUO_W; i++) begin
                r_fl[i] <= '0;
            end
        end else if (w_en) begin
            r_fl[0] <= r4_fl;
            for (int i = 1; i < wsp_pkg::QUO_W; i++) begin
                r_fl[i] <= r_fl[i-1];
            end
        end
    end

    // ---- final: cap, sign, viewport offset, saturate, zero when off-screen ----
    assign w_lf   = r_fl[wsp_pkg::QUO_W-1];
    assign w_capx = (w_lf.ovx || w_qx > wsp_pkg::QUO_CAP) ? wsp_pkg::QUO_CAP : w_qx;
    assign w_capy = (w_lf.ovy || w_qy > wsp_pkg::QUO_CAP) ? wsp_pkg::QUO_CAP : w_qy;

    assign w_tx = w_lf.negx ? -$signed(wsp_pkg::SUM_W'(w_capx))
                            :  $signed(wsp_pkg::SUM_W'(w_capx));
    assign w_ty = w_lf.negy ? -$signed(wsp_pkg::SUM_W'(w_capy))
                            :  $signed(wsp_pkg::SUM_W'(w_capy));

    assign w_sx = w_tx + $signed(wsp_pkg::SUM_W'(w_hw) << wsp_pkg::FRAC_BITS);
    assign w_sy = $signed(wsp_pkg::SUM_W'(w_hh) << wsp_pkg::FRAC_BITS) - w_ty;

    always_comb begin
        if (!w_lf.on) begin
            n_ox = '0;
        end else if (w_sx > wsp_pkg::SUM_W'(INT_MAX)) begin
            n_ox = INT_MAX;
        end else if (w_sx < wsp_pkg::SUM_W'(INT_MIN)) begin
            n_ox = INT_MIN;
        end else begin
            n_ox = w_sx[31:0];
        end
        if (!w_lf.on) begin
            n_oy = '0;
        end else if (w_sy > wsp_pkg::SUM_W'(INT_MAX)) begin
            n_oy = INT_MAX;
        end else if (w_sy < wsp_pkg::SUM_W'(INT_MIN)) begin
            n_oy = INT_MIN;
        end else begin
            n_oy = w_sy[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_lf.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_x  <= n_ox;
            r_out_y  <= n_oy;
            r_out_on <= w_lf.on;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_y, r_out_x};
    assign o_m_axis_tuser  = r_out_on;

endmodule
`default_nettype wire

@@ verif/world_to_screen_projection_tb.sv @@
`timescale 1ns / 1ps

// Tracks the coefficient store and screen size, predicts each projection
// result and checks the result stream in order.
class proj_scoreboard;
    logic [31:0] coefs[16];
    logic [14:0] width_px;
    logic [14:0] height_px;
    logic [64:0] pending_pos[$];   // {on_screen, screen_y, screen_x}
    int          errors;

    function void clear();
        foreach (coefs[k]) coefs[k] = '0;
        width_px    = 15'd1920;
        height_px   = 15'd1080;
        errors      = 0;
        pending_pos.delete();
    endfunction

    function void set_size(logic [1:0] idx, logic [14:0] val);
        if (idx == wsp_pkg::CFG_WIDTH) width_px = val;
        else if (idx == wsp_pkg::CFG_HEIGHT) height_px = val;
    endfunction

    // coef*coord, floored right shift by the fraction width
    function automatic longint floor_prod(logic [31:0] c, logic [31:0] p);
        longint prod;
        prod = longint'($signed(c)) * longint'($signed(p));
        return prod >>> wsp_pkg::FRAC_BITS;
    endfunction

    function automatic longint clip_of(int r, logic [31:0] px, logic [31:0] py,
                                       logic [31:0] pz);
        return floor_prod(coefs[r], px) + floor_prod(coefs[4 + r], py)
             + floor_prod(coefs[8 + r], pz) + longint'($signed(coefs[12 + r]));
    endfunction

    // half*clip/w in Q.F, truncated toward zero, capped at 2^40 in magnitude
    function automatic longint ndc_term(longint clip, longint half, longint w);
        logic [127:0] mag, q;
        mag = (clip < 0) ? 128'(-clip) : 128'(clip);
        q = (mag * 128'(half << wsp_pkg::FRAC_BITS)) / 128'(w);
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
        return (clip < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] sat(longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // note an accepted input beat
    function void take_beat(logic req, logic [135:0] d);
        longint cx, cy, cw, hw, hh;
        if (req == wsp_pkg::REQ_WRITE) begin
            coefs[d[3:0]] = d[35:4];
            return;
        end
        cx = clip_of(0, d[67:36], d[99:68], d[131:100]);
        cy = clip_of(1, d[67:36], d[99:68], d[131:100]);
        cw = clip_of(3, d[67:36], d[99:68], d[131:100]);
        if (cw < wsp_pkg::THR) begin
            pending_pos.push_back('0);
            return;
        end
        hw = width_px / 2;
        hh = height_px / 2;
        pending_pos.push_back({1'b1,
            sat((hh <<< wsp_pkg::FRAC_BITS) - ndc_term(cy, hh, cw)),
            sat(ndc_term(cx, hw, cw) + (hw <<< wsp_pkg::FRAC_BITS))});
    endfunction

    function void check_result(logic [63:0] d, logic on);
        logic [64:0] exp_v;
        if (pending_pos.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h on=%b", $realtime,
                     d[31:0], d[63:32], on);
            errors++;
            return;
        end
        exp_v = pending_pos.pop_front();
        if (exp_v[31:0] !== d[31:0]) begin
            $display("%0t: screen_x expected %h actual %h", $realtime,
                     exp_v[31:0], d[31:0]);
            errors++;
        end
        if (exp_v[63:32] !== d[63:32]) begin
            $display("%0t: screen_y expected %h actual %h", $realtime,
                     exp_v[63:32], d[63:32]);
            errors++;
        end
        if (exp_v[64] !== on) begin
            $display("%0t: on_screen expected %b actual %b", $realtime, exp_v[64], on);
            errors++;
        end
    endfunction
endclass

module world_to_screen_projection_tb;

    localparam int LATENCY = 47;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [14:0]  cfg_wdata = '0;
    logic         in_valid = 1'b0;
    logic         in_ready;
    logic [135:0] in_data = '0;
    logic         in_user = 1'b0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    logic [63:0]  out_data;
    logic         out_user;

    // 0: random idling, 1: never idle, 2: long hold-off
    int           sink_mode = 0;

    proj_scoreboard sb;

    world_to_screen_projection i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        // tdata: coef_index, coef_value, pos_x, pos_y, pos_z, pad
        .i_s_axis_tdata  (in_data),
        // tuser: req_type
        .i_s_axis_tuser  (in_user),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        // tdata: screen_x, screen_y
        .o_m_axis_tdata  (out_data),
        // tuser: on_screen
        .o_m_axis_tuser  (out_user)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // result side: sample and check at the edge, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) sb.check_result(out_data, out_user);
    end

    initial begin : sink
        int hold;
        forever begin
            @(posedge i_clk);
            if (sink_mode == 2) begin
                out_ready <= 1'b0;
                for (hold = 0; hold < 300; hold++) @(posedge i_clk);
                sink_mode = 0;
            end
            out_ready <= (sink_mode == 1) || ($urandom_range(99) >= 12);
        end
    end

    task automatic write_size(logic [1:0] idx, logic [14:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        sb.set_size(idx, val);
    endtask

    // offer one beat, hold it until accepted; idle beforehand if asked
    task automatic send_beat(logic req, logic [135:0] d, bit may_idle);
        while (may_idle && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_user  <= req;
        in_data  <= d;
        do @(posedge i_clk); while (!in_ready);
        sb.take_beat(req, d);
    endtask

    task automatic send_coef(logic [3:0] idx, logic [31:0] v, bit may_idle);
        send_beat(wsp_pkg::REQ_WRITE, {4'h0, 96'($urandom()), v, idx}, may_idle);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              bit may_idle);
        send_beat(wsp_pkg::REQ_PROJ, {4'h0, z, y, x, 36'($urandom())}, may_idle);
    endtask

    // wait until every result is in, plus pipeline slack
    task automatic drain();
        int n;
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_pos.size() != 0) @(posedge i_clk);
        for (n = 0; n < LATENCY + 8; n++) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(5))
            0:       return $urandom();
            1:       return $urandom_range(1, 0) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    // small random matrix with a positive w offset; fully random words when wild
    task automatic load_matrix(bit wild);
        int k;
        logic [31:0] v;
        for (k = 0; k < 16; k++) begin
            if (wild) v = $urandom();
            else if (k == 15) v = 32'($urandom_range(1 << 20));
            else if (k == 11) v = 32'($signed($urandom_range(1 << 17)) - (1 << 15));
            else v = 32'($signed($urandom_range(1 << 18)) - (1 << 17));
            send_coef(4'(k), v, 1'b1);
        end
    endtask

    initial begin : stim
        int n, k;
        logic [14:0] sizes[6];
        sb = new();
        sb.clear();
        sizes = '{15'd1, 15'd16384, 15'd0, 15'h7fff, 15'd1920, 15'd641};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero matrix gives off-screen
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0);
        // identity with w=1
        for (k = 0; k < 16; k++)
            send_coef(4'(k), (k % 5 == 0) ? 32'h0001_0000 : 32'h0, 1'b0);
        send_point(32'h0000_8000, 32'hffff_8000, 32'h0, 1'b0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        // w exactly at and just below threshold
        send_coef(4'd15, 32'(wsp_pkg::THR), 1'b0);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0, 1'b0);
        send_coef(4'd15, 32'(wsp_pkg::THR - 1), 1'b0);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0, 1'b0);
        send_coef(4'd15, 32'h8000_0000, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 1'b0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_size(wsp_pkg::CFG_WIDTH, sizes[ph]);
            write_size(wsp_pkg::CFG_HEIGHT, sizes[5 - ph]);
            write_size(2'd3, 15'($urandom()));
            load_matrix(ph == 3);
            if (ph == 2) sink_mode = 2;
            if (ph == 4) sink_mode = 1;
            for (n = 0; n < 290; n++) begin
                if ($urandom_range(9) == 0)
                    send_coef(4'($urandom()), (ph == 3) ? $urandom()
                              : 32'($signed($urandom_range(1 << 18)) - (1 << 17)),
                              sink_mode != 1);
                else
                    send_point(rnd_coord(), rnd_coord(), rnd_coord(), sink_mode != 1);
            end
            sink_mode = 0;
            drain();
        end

        if (sb.errors == 0 && sb.pending_pos.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
